[src/pvda_pkg.sv]
// Shared types and constants for the point vortex displacement accumulator.
`default_nettype none
package pvda_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] INV2PI_Q32 = 32'd683565276;
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;
  localparam logic [1:0] REG_IMAGES = 2'd3;

  // One queued job: a source with its strength split into sign and magnitude
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [30:0]        src_dist;
    logic               gneg;
    logic [31:0]        strength_mag;
    logic               last;
  } job_t;

  // Image shift signs: -1, 0, +1 coded as two bits {neg, nonzero}
  function automatic logic [1:0] img_sx(input logic [3:0] i);
    logic [1:0] r;
    case (i)
      4'd0, 4'd3, 4'd5: r = 2'b11;
      4'd2, 4'd4, 4'd7: r = 2'b01;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] img_sy(input logic [3:0] i);
    logic [1:0] r;
    case (i)
      4'd0, 4'd1, 4'd2: r = 2'b01;
      4'd5, 4'd6, 4'd7: r = 2'b11;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/pvda_front.sv]
// Front end: takes source words, pushes them into a small job queue.
`default_nettype none
module pvda_front import pvda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] offset_x,
  input  wire logic [31:0] offset_y,
  input  wire logic [30:0] distance,
  input  wire logic [31:0] strength,
  input  wire logic        last_source,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);

  job_t        q [2];
  logic [1:0]  cnt;
  logic        wp;
  logic        rp;
  logic        push;
  logic        pop;

  assign in_ready  = (cnt != 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].dx           <= offset_x;
      q[wp].dy           <= offset_y;
      q[wp].src_dist     <= distance;
      q[wp].gneg         <= strength[31];
      q[wp].strength_mag <= strength[31] ? (~strength + 32'd1) : strength;
      q[wp].last         <= last_source;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[src/pvda_back.sv]
// Back end: sequencer over home and image terms with shared sqrt/divide unit.
`default_nettype none
module pvda_back import pvda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  job_t             job,
  input  wire logic [30:0] dom_w,
  input  wire logic [30:0] dom_h,
  input  wire logic [15:0] step_len,
  input  wire logic [3:0]  n_img,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      shift_x,
  output logic [31:0]      shift_y,
  output logic             saturated
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_K     = 11'b00000000010,
    S_G     = 11'b00000000100,
    S_IMG   = 11'b00000001000,
    S_SQ    = 11'b00000010000,
    S_SQRT  = 11'b00000100000,
    S_CHK   = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_DIV1  = 11'b00100000000,
    S_DIV2  = 11'b01000000000,
    S_ACC   = 11'b10000000000
  } state_t;

  state_t       st;
  job_t         cur;
  logic [31:0]  k;
  logic [28:0]  g;
  logic [3:0]   idx;        // 0 = home, 1..8 = images
  logic [3:0]   nimg;
  logic signed [33:0] ix;
  logic signed [33:0] iy;
  logic [32:0]  ax;
  logic [32:0]  ay;
  logic [30:0]  r;
  logic         comp;       // 0: x term (uses dy), 1: y term (uses dx)
  logic [63:0]  prod;
  logic [63:0]  sq_acc;
  // shared iterative unit: restoring divider / sqrt, one bit per cycle
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic [6:0]   bitc;
  logic [63:0]  sq_n;
  logic [63:0]  sq_res;
  logic [63:0]  sq_bit;
  logic [40:0]  m;
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic         clip;
  logic         obusy;

  logic [63:0]  rem_sh;
  logic signed [34:0] s_new;
  logic signed [34:0] term;
  logic         tneg;
  logic [32:0]  dmag;
  logic         dneg;
  logic [1:0]   sxc;
  logic [1:0]   syc;

  assign job_ready = (st == S_IDLE) && !(job_valid && job.last && obusy);
  assign out_valid = obusy;

  // component operand selection
  always_comb begin
    sxc = img_sx(idx - 4'd1);
    syc = img_sy(idx - 4'd1);
    dneg = comp ? ix[33] : iy[33];
    dmag = comp ? ax : ay;
    tneg = comp ? !(cur.gneg != dneg) : (cur.gneg != dneg);
    rem_sh = {rem[62:0], quo[63]};
    term = tneg ? -$signed({1'b0, 1'b0, m[32:0]}) : $signed({2'b00, m[32:0]});
    if (m[40:33] != 8'd0) term = tneg ? -35'sd4294967296 : 35'sd4294967296;
    s_new = $signed({{2{(comp ? sum_y[32] : sum_x[32])}},
                     (comp ? sum_y : sum_x)}) + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      idx   <= 4'd0;
      sum_x <= '0;
      sum_y <= '0;
      clip  <= 1'b0;
      obusy <= 1'b0;
    end else begin
      if (obusy && out_ready) obusy <= 1'b0;
      case (st)
        S_IDLE: begin
          if (job_ready && job_valid) begin
            cur  <= job;
            nimg <= (n_img > 4'd8) ? 4'd8 : n_img;
            st   <= S_K;
          end
        end
        S_K: begin
          prod <= {48'd0, step_len} * {32'd0, INV2PI_Q32};
          st   <= S_G;
        end
        S_G: begin
          if (prod[15:0] == 16'd0 && prod[63:16] == 48'd0) k <= 32'd0;
          else k <= prod[47:16];
          st <= S_IMG;
          idx <= 4'd0;
        end
        S_IMG: begin
          // g uses k just registered
          g <= 29'(({32'd0, cur.strength_mag} * {32'd0, k}) >> 32);
          if (idx == 4'd0) begin
            ix <= 34'($signed(cur.dx));
            iy <= 34'($signed(cur.dy));
            ax <= cur.dx[31] ? 33'(-34'($signed(cur.dx))) : {1'b0, cur.dx};
            ay <= cur.dy[31] ? 33'(-34'($signed(cur.dy))) : {1'b0, cur.dy};
            r  <= cur.src_dist;
            st <= S_CHK;
          end else if (idx > nimg) begin
            if (cur.last) begin
              shift_x   <= sum_x[31:0];
              shift_y   <= sum_y[31:0];
              saturated <= clip;
              obusy     <= 1'b1;
              sum_x <= '0;
              sum_y <= '0;
              clip  <= 1'b0;
            end
            st <= S_IDLE;
          end else begin
            ix <= 34'($signed(cur.dx)) + (sxc[0] ?
                  (sxc[1] ? -34'({3'd0, dom_w}) : 34'({3'd0, dom_w})) : 34'd0);
            iy <= 34'($signed(cur.dy)) + (syc[0] ?
                  (syc[1] ? -34'({3'd0, dom_h}) : 34'({3'd0, dom_h})) : 34'd0);
            st <= S_SQ;
          end
        end
        S_SQ: begin
          ax <= ix[33] ? 33'(-ix) : ix[32:0];
          ay <= iy[33] ? 33'(-iy) : iy[32:0];
          sq_acc <= '0;
          bitc <= 7'd0;
          st <= S_SQRT;
        end
        S_SQRT: begin
          // steps 0 and 1: bounds check and squares; then 32 sqrt steps
          if (bitc == 7'd0) begin
            if (ax > {2'b0, dom_w} || ay > {2'b0, dom_w}) begin
              idx <= idx + 4'd1;
              st  <= S_IMG;
            end else begin
              sq_acc <= {32'd0, ax[31:0]} * {32'd0, ax[31:0]};
              bitc   <= 7'd1;
            end
          end else if (bitc == 7'd1) begin
            sq_n   <= sq_acc + ({32'd0, ay[31:0]} * {32'd0, ay[31:0]});
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            bitc   <= 7'd2;
          end else if (sq_bit != 64'd0) begin
            if (sq_n >= sq_res + sq_bit) begin
              sq_n   <= sq_n - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else if (sq_res[63:31] != 33'd0) begin
            // root wider than any domain width: past the cutoff
            idx <= idx + 4'd1;
            st  <= S_IMG;
          end else begin
            r  <= sq_res[30:0];
            st <= S_CHK;
          end
        end
        S_CHK: begin
          comp <= 1'b0;
          if (r == 31'd0 || r > dom_w) begin
            idx <= idx + 4'd1;
            st  <= S_IMG;
          end else begin
            st <= S_MUL;
          end
        end
        S_MUL: begin
          quo  <= 64'({29'd0, g} * {31'd0, dmag});
          rem  <= '0;
          bitc <= 7'd64;
          st   <= S_DIV1;
        end
        S_DIV1: begin
          // v = g*d / r, one quotient bit per cycle
          if (bitc != 7'd0) begin
            if (rem_sh >= {33'd0, r}) begin
              rem <= rem_sh - {33'd0, r};
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
            bitc <= bitc - 7'd1;
          end else if (quo >= (64'd1 << (62 - FRAC_BITS))) begin
            m  <= TERM_CAP;
            st <= S_ACC;
          end else begin
            quo  <= {quo[63 - FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            rem  <= '0;
            bitc <= 7'd64;
            st   <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (bitc != 7'd0) begin
            if (rem_sh >= {33'd0, r}) begin
              rem <= rem_sh - {33'd0, r};
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[62:0], 1'b0};
            end
            bitc <= bitc - 7'd1;
          end else begin
            m  <= (quo > {23'd0, TERM_CAP}) ? TERM_CAP : quo[40:0];
            st <= S_ACC;
          end
        end
        S_ACC: begin
          // saturating add into the selected sum
          if (s_new > 35'sd2147483647) begin
            if (comp) sum_y <= 33'sd2147483647; else sum_x <= 33'sd2147483647;
            clip <= 1'b1;
          end else if (s_new < -35'sd2147483648) begin
            if (comp) sum_y <= -33'sd2147483648; else sum_x <= -33'sd2147483648;
            clip <= 1'b1;
          end else begin
            if (comp) sum_y <= s_new[32:0]; else sum_x <= s_new[32:0];
          end
          if (!comp) begin
            comp <= 1'b1;
            st   <= S_MUL;
          end else begin
            idx <= idx + 4'd1;
            st  <= S_IMG;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= 4'd9) else $error("image index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    obusy && !out_ready |=> obusy) else $error("result dropped");
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    st == S_IMG |-> sum_x[32] == sum_x[31] && sum_y[32] == sum_y[31])
    else $error("sum out of range");
`endif

endmodule
`default_nettype wire

[src/point_vortex_displacement_accumulator.sv]
// Top level: configuration registers, front queue and back sequencer.
//
//  channel  signals                                        dir
//  in       in_valid/in_ready, offset_x..last_source        in
//  out      out_valid/out_ready, shift_x, shift_y, saturated out
//  cfg      cfg_we, cfg_index, cfg_data                    in
//
// In the back end each counted term runs two 64-step divides per component on
// one shared unit, the second skipped when the first already caps the term;
// each image adds a bounds check and a 32-step square root, the root being
// skipped when the image fails the bounds check. Reset is synchronous and
// clears sums, queue and result. A held result stalls only the last-source word.
`default_nettype none
module point_vortex_displacement_accumulator import pvda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] offset_x,
  input  wire logic [31:0] offset_y,
  input  wire logic [30:0] distance,
  input  wire logic [31:0] strength,
  input  wire logic        last_source,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      shift_x,
  output logic [31:0]      shift_y,
  output logic             saturated,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  logic [30:0] dom_w;
  logic [30:0] dom_h;
  logic [15:0] step_len;
  logic [3:0]  n_img;
  logic        job_valid;
  logic        job_ready;
  job_t        job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dom_w    <= 31'd6553600;
      dom_h    <= 31'd6553600;
      step_len <= 16'd655;
      n_img    <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  dom_w    <= cfg_data;
        REG_HEIGHT: dom_h    <= cfg_data;
        REG_STEP:   step_len <= cfg_data[15:0];
        REG_IMAGES: n_img    <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  pvda_front u_front (
    .clk, .rst, .in_valid, .in_ready, .offset_x, .offset_y, .distance,
    .strength, .last_source, .job_valid, .job_ready, .job
  );

  pvda_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .dom_w, .dom_h, .step_len,
    .n_img, .out_valid, .out_ready, .shift_x, .shift_y, .saturated
  );

endmodule
`default_nettype wire

[tb/tb_point_vortex_displacement_accumulator.sv]
// Testbench for the point vortex displacement accumulator: random sources, self-checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_point_vortex_displacement_accumulator;
  import pvda_pkg::*;

  typedef struct {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [30:0] rad;
    logic [31:0] gam;
    logic        last;
  } src_word_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        sat;
  } shift_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] offset_x = '0;
  logic [31:0] offset_y = '0;
  logic [30:0] distance = '0;
  logic [31:0] strength = '0;
  logic        last_source = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] shift_x;
  logic [31:0] shift_y;
  logic        saturated;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [30:0] cfg_data = '0;

  point_vortex_displacement_accumulator dut (.*);

  always #2 clk = ~clk;

  // Model copy of the registers and running sums
  longint unsigned m_width, m_height, m_step, m_images;
  longint          acc_x, acc_y;
  bit              acc_clip;

  src_word_t   pending_src[$];
  shift_word_t expected_shift[$];
  int          n_errors = 0;
  bit          calm = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned absl(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // g*d/r^2 in Q format, capped
  function automatic longint unsigned induced_mag(input longint unsigned g, d, r);
    longint unsigned v, m;
    v = (g * d) / r;
    if (v >= (64'd1 << (62 - FRAC_BITS))) return 64'd1 << 40;
    m = (v << FRAC_BITS) / r;
    return m > (64'd1 << 40) ? (64'd1 << 40) : m;
  endfunction

  task automatic clamp_add(inout longint s, input longint unsigned m, input bit neg);
    longint t;
    t = neg ? -longint'(m) : longint'(m);
    s = s + t;
    if (s > 64'sd2147483647) begin
      s = 64'sd2147483647;
      acc_clip = 1'b1;
    end else if (s < -64'sd2147483648) begin
      s = -64'sd2147483648;
      acc_clip = 1'b1;
    end
  endtask

  task automatic add_vortex_term(input longint dx, dy, input longint unsigned r, g,
                                 input bit gneg);
    if (r == 0 || r > m_width) return;
    clamp_add(acc_x, induced_mag(g, absl(dy), r), gneg != (dy < 0));
    clamp_add(acc_y, induced_mag(g, absl(dx), r), !(gneg != (dx < 0)));
  endtask

  // Fold one accepted source word into the sums; queue a result on the last one
  task automatic predict_shift(input src_word_t w);
    int sxs[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int sys[8] = '{1, 1, 1, 0, 0, -1, -1, -1};
    longint dx, dy, gs, ix, iy;
    longint unsigned k, g, ax, ay, n;
    shift_word_t e;
    dx = longint'($signed(w.ox));
    dy = longint'($signed(w.oy));
    gs = longint'($signed(w.gam));
    k = (m_step * 64'(INV2PI_Q32)) >> 16;
    g = (absl(gs) * k) >> 32;
    n = m_images > 8 ? 8 : m_images;
    add_vortex_term(dx, dy, w.rad, g, gs < 0);
    for (int i = 0; i < n; i++) begin
      ix = dx + sxs[i] * longint'(m_width);
      iy = dy + sys[i] * longint'(m_height);
      ax = absl(ix);
      ay = absl(iy);
      if (ax > m_width || ay > m_width) continue;
      add_vortex_term(ix, iy, root64(ax * ax + ay * ay), g, gs < 0);
    end
    if (w.last) begin
      e.sx = acc_x[31:0];
      e.sy = acc_y[31:0];
      e.sat = acc_clip;
      expected_shift.push_back(e);
      acc_x = 0;
      acc_y = 0;
      acc_clip = 1'b0;
    end
  endtask

  // Source driver with random idle bursts
  int src_idle = 0;
  always @(posedge clk) begin
    src_word_t w;
    bit nv;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_shift('{offset_x, offset_y, distance, strength, last_source});
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_idle > 0) begin
          src_idle--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_idle = $urandom_range(1, 9);
        end else if (pending_src.size() > 0) begin
          w = pending_src.pop_front();
          offset_x <= w.ox;
          offset_y <= w.oy;
          distance <= w.rad;
          strength <= w.gam;
          last_source <= w.last;
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
  end

  // Result monitor with random stall bursts
  int sink_stall = 0;
  always @(posedge clk) begin
    shift_word_t e;
    bit nr;
    if (!rst && out_valid && out_ready) begin
      if (expected_shift.size() == 0) begin
        report("unexpected word", shift_x, 32'h0);
      end else begin
        e = expected_shift.pop_front();
        if (shift_x !== e.sx) report("shift_x", shift_x, e.sx);
        if (shift_y !== e.sy) report("shift_y", shift_y, e.sy);
        if (saturated !== e.sat) report("saturated", 32'(saturated), 32'(e.sat));
      end
    end
    if (calm) begin
      nr = 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      nr = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(1, 9);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    out_ready <= nr;
  end

  task automatic write_reg(input logic [1:0] idx, input longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    case (idx)
      REG_WIDTH:  m_width = val & 64'h7FFF_FFFF;
      REG_HEIGHT: m_height = val & 64'h7FFF_FFFF;
      REG_STEP:   m_step = val & 64'hFFFF;
      REG_IMAGES: m_images = val & 64'hF;
      default:    ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input longint unsigned w, h, s, n);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STEP, s);
    write_reg(REG_IMAGES, n);
  endtask

  // Drain: all words sent, all results back, then the block's own latency
  task automatic drain();
    while (pending_src.size() > 0 || in_valid || expected_shift.size() > 0) @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  task automatic push_src(input logic [31:0] ox, oy, input logic [30:0] d,
                          input logic [31:0] g, input logic l);
    pending_src.push_back('{ox, oy, d, g, l});
  endtask

  // Mostly offsets inside the domain with a consistent distance, some raw noise
  task automatic random_sources(input int n);
    longint dx, dy;
    longint unsigned r, span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        span = m_width > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : m_width;
        dx = longint'($urandom_range(0, 32'(2 * span))) - longint'(span);
        dy = longint'($urandom_range(0, 32'(2 * span))) - longint'(span);
        r = root64(absl(dx) * absl(dx) + absl(dy) * absl(dy));
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        push_src(dx[31:0], dy[31:0], r[30:0], $urandom, $urandom_range(0, 5) == 0);
      end else begin
        push_src($urandom, $urandom, 31'($urandom), $urandom, $urandom_range(0, 5) == 0);
      end
    end
    push_src('0, '0, '0, '0, 1'b1);
  endtask

  initial begin
    m_width = 6553600;
    m_height = 6553600;
    m_step = 655;
    m_images = 0;
    acc_x = 0;
    acc_y = 0;
    acc_clip = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset config, home domain only
    push_src(32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 32'h0001_0000, 1'b1);
    push_src(32'h0, 32'h0, 31'h0, 32'h7FFF_FFFF, 1'b1);               // zero distance
    push_src(32'h0001_0000, 32'h0001_0000, 31'd6553601, 32'h0001_0000, 1'b1); // past cutoff
    push_src(32'h0064_0000, 32'h0, 31'd6553600, 32'h8000_0000, 1'b1); // at cutoff
    push_src(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 1'b0);  // saturating
    push_src(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 32'h8000_0000, 1'b0);
    push_src(32'hFFFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_src(32'hFFFF_0000, 32'hFFFF_0000, 31'h0001_6A09, 32'h0010_0000, 1'b0);
    push_src(32'h0000_0100, 32'hFFFF_FF00, 31'h0000_016A, 32'hFFF0_0000, 1'b1);
    drain();

    // Directed: all images, zero image offset and extreme step
    set_config(6553600, 3276800, 65535, 8);
    push_src(32'h0064_0000, 32'h0, 31'd6553600, 32'h0100_0000, 1'b1);  // image lands on target
    push_src(32'h0010_0000, 32'hFFF0_0000, 31'h0016_A09E, 32'h8000_0000, 1'b1);
    push_src(32'h0, 32'h0032_0000, 31'd3276800, 32'h7FFF_FFFF, 1'b1);
    push_src(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 32'h1234_5678, 1'b1);
    random_sources(40);
    drain();

    set_config(64'h7FFF_FFFF, 64'h7FFF_FFFF, 65535, 15);
    random_sources(30);
    drain();

    set_config(1, 1, 0, 8);
    random_sources(30);
    drain();

    set_config(64'h0010_0000, 64'h0020_0000, 40000, 2);
    random_sources(120);
    drain();

    set_config(64'h0001_0000, 64'h0000_8000, 1, 4);
    random_sources(80);
    drain();

    set_config(64'h0400_0000, 64'h0100_0000, 12000, 1);
    random_sources(100);
    drain();

    // Final stretch without idling on either side
    calm = 1'b1;
    set_config(6553600, 6553600, 655, 0);
    random_sources(80);
    drain();

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
